FILE: hdl/ibt_pkg.sv
// ibt_pkg: shared types, codes and defaults of the indent and bracket tracker
// used by ibt_seq, ibt_out and the top level; depends on nothing
`default_nettype none

package ibt_pkg;

  // default stack depths
  localparam int unsigned BRACKET_DEPTH_DEF = 32;
  localparam int unsigned INDENT_DEPTH_DEF  = 32;

  // operation codes
  localparam logic OP_TOKEN = 1'b0;
  localparam logic OP_EOI   = 1'b1;

  // token classes
  localparam logic [2:0] CLS_OTHER   = 3'd0;
  localparam logic [2:0] CLS_OPEN    = 3'd1;
  localparam logic [2:0] CLS_CLOSE   = 3'd2;
  localparam logic [2:0] CLS_NEWLINE = 3'd3;
  localparam logic [2:0] CLS_CONT    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PASS   = 2'd0;
  localparam logic [1:0] KIND_INDENT = 2'd1;
  localparam logic [1:0] KIND_UNDENT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_MISALIGN  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_POP,
    S_WAIT,
    S_EOI
  } state_e;

  // one result beat from the sequencer to the output stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [1:0]  err;
    logic [31:0] pos;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/ibt_ram.sv
// ibt_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ibt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/ibt_out.sv
// ibt_out: output register stage that holds one result beat under stall
// depends on ibt_pkg for the result struct
`default_nettype none

module ibt_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          emit_i,
  input  wire ibt_pkg::res_t res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ibt_pkg::res_t      res_o
);

  logic          valid_q, valid_d;
  ibt_pkg::res_t res_q;

  // slot is free when empty or being drained this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = emit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: hdl/ibt_seq.sv
// ibt_seq: token sequencer with bracket and indent stacks kept in two rams
// depends on ibt_pkg and ibt_ram
`default_nettype none

module ibt_seq #(
  parameter int unsigned BRACKET_DEPTH = ibt_pkg::BRACKET_DEPTH_DEF,
  parameter int unsigned INDENT_DEPTH  = ibt_pkg::INDENT_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [2:0]  token_class_i,
  input  wire logic [1:0]  bracket_kind_i,
  input  wire logic [7:0]  token_code_i,
  input  wire logic [7:0]  next_indent_i,
  input  wire logic [31:0] text_position_i,
  input  wire logic        out_ready_i,
  output logic             emit_o,
  output ibt_pkg::res_t    res_o
);

  localparam int unsigned BCW = $clog2(BRACKET_DEPTH + 1);
  localparam int unsigned BAW = $clog2(BRACKET_DEPTH);
  localparam int unsigned ITW = $clog2(INDENT_DEPTH);

  ibt_pkg::state_e state_q, state_d;

  // captured input beat
  logic        op_q;
  logic [2:0]  cls_q;
  logic [1:0]  bkind_q;
  logic [7:0]  code_q;
  logic [7:0]  nxt_q;
  logic [31:0] pos_q;

  // stack pointers and cached indent level of the top entry
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [ITW-1:0] itop_q, itop_d;
  logic [7:0]     lvl_q, lvl_d;
  logic           halted_q, halted_d;

  // ram ports
  logic           b_we;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [1:0]     b_rdata;
  logic           i_we;
  logic [ITW-1:0] i_waddr, i_raddr;
  logic [7:0]     i_rdata;

  logic       accept;
  logic [7:0] pop_lvl;

  assign accept     = (state_q == ibt_pkg::S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ibt_pkg::S_IDLE);

  // bracket read port looks at the top entry, indent read port one below the top
  assign b_raddr = b_waddr - BAW'(1);
  assign i_raddr = itop_q - ITW'(1);

  // level after a pop; entry zero is never written and is read as level zero
  assign pop_lvl = (itop_q == ITW'(1)) ? 8'd0 : i_rdata;

  ibt_ram #(
    .WIDTH (2),
    .DEPTH (BRACKET_DEPTH)
  ) u_bracket_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (bkind_q),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  ibt_ram #(
    .WIDTH (8),
    .DEPTH (INDENT_DEPTH)
  ) u_indent_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (nxt_q),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  assign b_waddr = bcnt_q[BAW-1:0];
  assign i_waddr = itop_q + ITW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ibt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ibt_pkg::S_EXEC;
      end
      ibt_pkg::S_EXEC: begin
        if (halted_q) begin
          state_d = ibt_pkg::S_IDLE;
        end else if (op_q == ibt_pkg::OP_EOI) begin
          state_d = (itop_q == '0) ? ibt_pkg::S_IDLE : ibt_pkg::S_EOI;
        end else begin
          case (cls_q)
            ibt_pkg::CLS_NEWLINE: begin
              if (bcnt_q != '0) begin
                state_d = ibt_pkg::S_IDLE;
              end else if (out_ready_i) begin
                if (nxt_q > lvl_q)      state_d = ibt_pkg::S_PUSH;
                else if (nxt_q < lvl_q) state_d = ibt_pkg::S_POP;
                else                    state_d = ibt_pkg::S_IDLE;
              end
            end
            ibt_pkg::CLS_CONT: state_d = ibt_pkg::S_IDLE;
            default: begin
              if (out_ready_i) state_d = ibt_pkg::S_IDLE;
            end
          endcase
        end
      end
      ibt_pkg::S_PUSH: begin
        if (out_ready_i) state_d = ibt_pkg::S_IDLE;
      end
      ibt_pkg::S_POP: begin
        if (out_ready_i) begin
          if ((itop_q != '0) && (nxt_q < lvl_q) && (pop_lvl != nxt_q)) begin
            state_d = ibt_pkg::S_WAIT;
          end else begin
            state_d = ibt_pkg::S_IDLE;
          end
        end
      end
      ibt_pkg::S_WAIT: state_d = ibt_pkg::S_POP;
      ibt_pkg::S_EOI: begin
        if (out_ready_i && (itop_q == ITW'(1))) state_d = ibt_pkg::S_IDLE;
      end
      default: state_d = ibt_pkg::S_IDLE;
    endcase
  end

  // result beats and stack updates
  always_comb begin
    emit_o   = 1'b0;
    res_o    = '{kind: ibt_pkg::KIND_PASS, code: 8'd0, err: ibt_pkg::ERR_NONE,
                 pos: pos_q, last: 1'b0};
    bcnt_d   = bcnt_q;
    itop_d   = itop_q;
    lvl_d    = lvl_q;
    halted_d = halted_q;
    b_we     = 1'b0;
    i_we     = 1'b0;
    case (state_q)
      ibt_pkg::S_EXEC: begin
        if (!halted_q) begin
          if (op_q == ibt_pkg::OP_EOI) begin
            bcnt_d = '0;
            lvl_d  = 8'd0;
          end else begin
            case (cls_q)
              ibt_pkg::CLS_OPEN: begin
                if (out_ready_i) begin
                  emit_o       = 1'b1;
                  res_o.last   = 1'b1;
                  if (bcnt_q == BCW'(BRACKET_DEPTH)) begin
                    res_o.kind = ibt_pkg::KIND_ERROR;
                    res_o.err  = ibt_pkg::ERR_OVERFLOW;
                    halted_d   = 1'b1;
                  end else begin
                    b_we       = 1'b1;
                    bcnt_d     = bcnt_q + BCW'(1);
                    res_o.code = code_q;
                  end
                end
              end
              ibt_pkg::CLS_CLOSE: begin
                if (out_ready_i) begin
                  emit_o       = 1'b1;
                  res_o.last   = 1'b1;
                  if ((bcnt_q == '0) || (b_rdata != bkind_q)) begin
                    res_o.kind = ibt_pkg::KIND_ERROR;
                    res_o.err  = ibt_pkg::ERR_UNMATCHED;
                    halted_d   = 1'b1;
                  end else begin
                    bcnt_d     = bcnt_q - BCW'(1);
                    res_o.code = code_q;
                  end
                end
              end
              ibt_pkg::CLS_NEWLINE: begin
                if ((bcnt_q == '0) && out_ready_i) begin
                  emit_o     = 1'b1;
                  res_o.code = code_q;
                  res_o.last = (nxt_q == lvl_q);
                end
              end
              ibt_pkg::CLS_CONT: begin
                emit_o = 1'b0;
              end
              default: begin
                if (out_ready_i) begin
                  emit_o     = 1'b1;
                  res_o.code = code_q;
                  res_o.last = 1'b1;
                end
              end
            endcase
          end
        end
      end
      // deeper line: push a new level, or an overflow error if the indent stack is full
      ibt_pkg::S_PUSH: begin
        if (out_ready_i) begin
          emit_o     = 1'b1;
          res_o.last = 1'b1;
          if (itop_q == ITW'(INDENT_DEPTH - 1)) begin
            res_o.kind = ibt_pkg::KIND_ERROR;
            res_o.err  = ibt_pkg::ERR_OVERFLOW;
            halted_d   = 1'b1;
          end else begin
            i_we       = 1'b1;
            itop_d     = itop_q + ITW'(1);
            lvl_d      = nxt_q;
            res_o.kind = ibt_pkg::KIND_INDENT;
          end
        end
      end
      // one unindent per visit, then misalignment check
      ibt_pkg::S_POP: begin
        if (out_ready_i) begin
          emit_o = 1'b1;
          if ((itop_q != '0) && (nxt_q < lvl_q)) begin
            res_o.kind = ibt_pkg::KIND_UNDENT;
            res_o.last = (pop_lvl == nxt_q);
            itop_d     = itop_q - ITW'(1);
            lvl_d      = pop_lvl;
          end else begin
            res_o.kind = ibt_pkg::KIND_ERROR;
            res_o.err  = ibt_pkg::ERR_MISALIGN;
            res_o.last = 1'b1;
            halted_d   = 1'b1;
          end
        end
      end
      // end of input: close every open level
      ibt_pkg::S_EOI: begin
        if (out_ready_i) begin
          emit_o     = 1'b1;
          res_o.kind = ibt_pkg::KIND_UNDENT;
          res_o.last = (itop_q == ITW'(1));
          itop_d     = itop_q - ITW'(1);
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ibt_pkg::S_IDLE;
      bcnt_q   <= '0;
      itop_q   <= '0;
      lvl_q    <= 8'd0;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bcnt_q   <= bcnt_d;
      itop_q   <= itop_d;
      lvl_q    <= lvl_d;
      halted_q <= halted_d;
    end
  end

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      cls_q   <= token_class_i;
      bkind_q <= bracket_kind_i;
      code_q  <= token_code_i;
      nxt_q   <= next_indent_i;
      pos_q   <= text_position_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/indent_bracket_tracker_unit.sv
// indent_bracket_tracker_unit: top level of the indent and bracket tracker
// depends on ibt_pkg, ibt_seq (with ibt_ram) and ibt_out
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid_i/in_stall_o | operation, class, kind, code, indent, pos
//   out     | output    | out_valid_o/out_stall_i | kind, code, error, position, last
//
// a beat is taken in idle and run in the next cycle; the input then stalls until the
// sequencer is idle. an indent adds a push state, an unindent a pop state, each pop
// after the first behind a wait state for the indent ram; a misaligned level adds a pop
// that flags the error; end of input pops the open levels in turn. reset empties both
// stacks at once; entry zero of the indent stack is never written and reads as level
// zero, so no clearing pass runs. a stalled output holds the sequencer and input.
`default_nettype none

module indent_bracket_tracker_unit #(
  parameter int unsigned BRACKET_DEPTH = ibt_pkg::BRACKET_DEPTH_DEF,
  parameter int unsigned INDENT_DEPTH  = ibt_pkg::INDENT_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [2:0]  token_class_i,
  input  wire logic [1:0]  bracket_kind_i,
  input  wire logic [7:0]  token_code_i,
  input  wire logic [7:0]  next_indent_i,
  input  wire logic [31:0] text_position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_token_code_o,
  output logic [1:0]       error_code_o,
  output logic [31:0]      out_position_o,
  output logic             last_o
);

  logic          emit;
  logic          out_ready;
  ibt_pkg::res_t res_seq;
  ibt_pkg::res_t res_out;

  // sequencer with both stacks
  ibt_seq #(
    .BRACKET_DEPTH (BRACKET_DEPTH),
    .INDENT_DEPTH  (INDENT_DEPTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .token_class_i   (token_class_i),
    .bracket_kind_i  (bracket_kind_i),
    .token_code_i    (token_code_i),
    .next_indent_i   (next_indent_i),
    .text_position_i (text_position_i),
    .out_ready_i     (out_ready),
    .emit_o          (emit),
    .res_o           (res_seq)
  );

  // output register
  ibt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .res_i       (res_seq),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign out_kind_o       = res_out.kind;
  assign out_token_code_o = res_out.code;
  assign error_code_o     = res_out.err;
  assign out_position_o   = res_out.pos;
  assign last_o           = res_out.last;

endmodule

`default_nettype wire

FILE: tb/sv/indent_bracket_tracker_unit_test.sv
// indent_bracket_tracker_unit_test: self-checking bench for the indent and bracket tracker
// drives token beats, predicts indent, unindent and error beats, checks each output beat
// depends on ibt_pkg and indent_bracket_tracker_unit
module indent_bracket_tracker_unit_test;
  import ibt_pkg::*;

  localparam int unsigned BDEPTH = BRACKET_DEPTH_DEF;
  localparam int unsigned IDEPTH = INDENT_DEPTH_DEF;
  // longest legal quiet stretch is the receiver hold plus a full unindent run
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // spare token classes, passed through like ordinary tokens
  localparam logic [2:0] CLS_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CLS_SPARE_MID   = 3'd6;
  localparam logic [2:0] CLS_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {BK_PAREN, BK_SQUARE, BK_BRACE, BK_UNKNOWN} bracket_kind_e;

  typedef struct packed {
    logic        op;
    logic [2:0]  cls;
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [7:0]  nxt;
    logic [31:0] pos;
  } token_beat_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        operation_i     = OP_TOKEN;
  logic [2:0]  token_class_i   = CLS_OTHER;
  logic [1:0]  bracket_kind_i  = BK_PAREN;
  logic [7:0]  token_code_i    = 8'h00;
  logic [7:0]  next_indent_i   = 8'h00;
  logic [31:0] text_position_i = 32'h0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_token_code_o;
  logic [1:0]  error_code_o;
  logic [31:0] out_position_o;
  logic        last_o;

  // shadow of the tracker state
  logic [1:0]  open_kinds [BDEPTH];
  int unsigned open_count = 0;
  logic [7:0]  level_shadow [IDEPTH];
  int unsigned indent_top = 0;
  bit          tracker_halted = 1'b0;

  // output beats still owed by the block, oldest first
  res_t        owed_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned beats_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned input_stalls  = 0;
  string       closing_error = "none";
  res_t        seen_res;
  res_t        want_res;

  indent_bracket_tracker_unit #(
    .BRACKET_DEPTH(BDEPTH),
    .INDENT_DEPTH (IDEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .token_class_i   (token_class_i),
    .bracket_kind_i  (bracket_kind_i),
    .token_code_i    (token_code_i),
    .next_indent_i   (next_indent_i),
    .text_position_i (text_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_kind_o      (out_kind_o),
    .out_token_code_o(out_token_code_o),
    .error_code_o    (error_code_o),
    .out_position_o  (out_position_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void owe_result(input logic [1:0] k, input logic [7:0] c,
                                     input logic [1:0] e, input logic [31:0] p);
    res_t r;
    r = '{kind: k, code: c, err: e, pos: p, last: 1'b0};
    owed_results.insert(owed_results.size(), r);
  endfunction

  function automatic void owe_error(input logic [1:0] e, input logic [31:0] p);
    tracker_halted = 1'b1;
    owe_result(KIND_ERROR, 8'h00, e, p);
  endfunction

  // expected output beats of one accepted token beat
  function automatic void offside_predict(input token_beat_t b);
    int unsigned first;
    res_t        tail;
    first = owed_results.size();
    if (tracker_halted) return;
    if (b.op == OP_EOI) begin
      while (indent_top > 0) begin
        indent_top--;
        owe_result(KIND_UNDENT, 8'h00, ERR_NONE, b.pos);
      end
      open_count = 0;
    end else begin
      case (b.cls)
        CLS_OPEN: begin
          if (open_count >= BDEPTH) begin
            owe_error(ERR_OVERFLOW, b.pos);
          end else begin
            open_kinds[open_count] = b.kind;
            open_count++;
            owe_result(KIND_PASS, b.code, ERR_NONE, b.pos);
          end
        end
        CLS_CLOSE: begin
          if (open_count == 0 || open_kinds[open_count-1] != b.kind) begin
            owe_error(ERR_UNMATCHED, b.pos);
          end else begin
            open_count--;
            owe_result(KIND_PASS, b.code, ERR_NONE, b.pos);
          end
        end
        CLS_NEWLINE: begin
          // newline inside brackets is swallowed
          if (open_count == 0) begin
            owe_result(KIND_PASS, b.code, ERR_NONE, b.pos);
            if (b.nxt > level_shadow[indent_top]) begin
              if (indent_top + 1 >= IDEPTH) begin
                owe_error(ERR_OVERFLOW, b.pos);
              end else begin
                indent_top++;
                level_shadow[indent_top] = b.nxt;
                owe_result(KIND_INDENT, 8'h00, ERR_NONE, b.pos);
              end
            end else begin
              while (indent_top > 0 && b.nxt < level_shadow[indent_top]) begin
                indent_top--;
                owe_result(KIND_UNDENT, 8'h00, ERR_NONE, b.pos);
              end
              if (level_shadow[indent_top] != b.nxt) owe_error(ERR_MISALIGN, b.pos);
            end
          end
        end
        CLS_CONT: ;
        default: owe_result(KIND_PASS, b.code, ERR_NONE, b.pos);
      endcase
    end
    // flag the final beat of this token
    if (owed_results.size() > first) begin
      tail = owed_results[owed_results.size() - 1];
      tail.last = 1'b1;
      owed_results[owed_results.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic token_beat_t token_of(input logic [2:0] cls, input logic [1:0] kind,
                                           input logic [7:0] nxt);
    token_beat_t b;
    b.op   = OP_TOKEN;
    b.cls  = cls;
    b.kind = kind;
    b.code = 8'($urandom);
    b.nxt  = nxt;
    b.pos  = $urandom;
    return b;
  endfunction

  function automatic token_beat_t eoi_beat();
    token_beat_t b;
    b = token_of(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 8'($urandom));
    b.op = OP_EOI;
    return b;
  endfunction

  // a legal token chosen against the current shadow state
  function automatic token_beat_t wellformed_beat();
    token_beat_t b;
    int unsigned pick;
    int unsigned room;
    logic [7:0]  cur;
    pick = $urandom_range(0, 99);
    cur  = level_shadow[indent_top];
    b    = token_of(CLS_OTHER, 2'($urandom_range(0, 3)), 8'($urandom));
    if (pick < 20) begin
      b.cls = CLS_OTHER;
    end else if (pick < 27) begin
      b.cls = 3'($urandom_range(CLS_SPARE_FIRST, CLS_SPARE_LAST));
    end else if (pick < 44) begin
      b.cls = (open_count < BDEPTH) ? CLS_OPEN : CLS_OTHER;
    end else if (pick < 65) begin
      if (open_count > 0) begin
        b.cls  = CLS_CLOSE;
        b.kind = open_kinds[open_count-1];
      end else begin
        b.cls = CLS_OPEN;
      end
    end else if (pick < 88) begin
      b.cls = CLS_NEWLINE;
      if ($urandom_range(0, 1) == 1 && indent_top + 1 < IDEPTH && cur < 8'hff) begin
        room = 255 - cur;
        if (room > 16) room = 16;
        b.nxt = 8'(cur + $urandom_range(1, room));
      end else begin
        b.nxt = level_shadow[$urandom_range(0, indent_top)];
      end
    end else if (pick < 94) begin
      b.cls = CLS_CONT;
    end else begin
      b.op = OP_EOI;
    end
    return b;
  endfunction

  // offer one beat, with random idle cycles ahead of it
  task automatic send_beat(input token_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= b.op;
    token_class_i   <= b.cls;
    bracket_kind_i  <= b.kind;
    token_code_i    <= b.code;
    next_indent_i   <= b.nxt;
    text_position_i <= b.pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    offside_predict(b);
    beats_sent++;
  endtask

  // one newline per level, each deeper by about eight spaces, top level below 255
  task automatic climb_indents(input int unsigned levels);
    for (int i = 1; i <= levels; i++)
      send_beat(token_of(CLS_NEWLINE, 2'($urandom_range(0, 3)),
                         8'(8 * i + $urandom_range(0, 6))));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    token_beat_t b;
    b = token_of(CLS_OTHER, BK_PAREN, 8'h00);
    b.code = 8'h00;
    b.pos  = 32'h0;
    send_beat(b);
    b = token_of(CLS_SPARE_FIRST, BK_UNKNOWN, 8'hff);
    b.code = 8'hff;
    b.pos  = 32'hffff_ffff;
    send_beat(b);
    send_beat(token_of(CLS_SPARE_MID, BK_BRACE, 8'h55));
    send_beat(token_of(CLS_SPARE_LAST, BK_SQUARE, 8'haa));
    // every bracket kind, the unknown one too
    send_beat(token_of(CLS_OPEN, BK_PAREN, 8'h00));
    send_beat(token_of(CLS_OPEN, BK_SQUARE, 8'h00));
    send_beat(token_of(CLS_OPEN, BK_BRACE, 8'h00));
    send_beat(token_of(CLS_OPEN, BK_UNKNOWN, 8'h00));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'h20));
    send_beat(token_of(CLS_CONT, BK_PAREN, 8'h00));
    send_beat(token_of(CLS_CLOSE, BK_UNKNOWN, 8'h00));
    send_beat(token_of(CLS_CLOSE, BK_BRACE, 8'h00));
    send_beat(token_of(CLS_CLOSE, BK_SQUARE, 8'h00));
    send_beat(token_of(CLS_CLOSE, BK_PAREN, 8'h00));
    // indent, deepest level, same level, dedents, indent again
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd4));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd255));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd255));
    send_beat(token_of(CLS_CONT, BK_BRACE, 8'd0));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd4));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd0));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd9));
    // end of input with one open level, then with none
    send_beat(eoi_beat());
    send_beat(eoi_beat());
    // end of input also empties the bracket stack
    send_beat(token_of(CLS_OPEN, BK_BRACE, 8'd0));
    send_beat(eoi_beat());
    send_beat(token_of(CLS_NEWLINE, BK_SQUARE, 8'd0));
  endtask

  // full bracket stack, a few closes from the top, end of input drops the rest
  task automatic test_deep_stacks();
    send_beat(eoi_beat());
    for (int i = 0; i < BDEPTH; i++)
      send_beat(token_of(CLS_OPEN, 2'($urandom_range(0, 3)), 8'($urandom)));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'($urandom)));
    for (int i = 0; i < 3; i++)
      send_beat(token_of(CLS_CLOSE, open_kinds[open_count-1], 8'($urandom)));
    send_beat(eoi_beat());
  endtask

  task automatic test_random_stream(input int unsigned count);
    for (int i = 0; i < count; i++) send_beat(wellformed_beat());
  endtask

  // full indent stack and one long dedent run under a receiver hold
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_beat(eoi_beat());
    climb_indents(IDEPTH - 1);
    send_beat(token_of(CLS_OTHER, BK_PAREN, 8'd0));
    send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd0));
    test_random_stream(2);
  endtask

  // one error per run, since only reset clears the halt
  task automatic test_halt_on_error();
    logic [1:0] k;
    int unsigned lo;
    int unsigned hi;
    send_beat(eoi_beat());
    case ($urandom_range(0, 4))
      0: begin
        closing_error = "close bracket on empty stack";
        send_beat(token_of(CLS_CLOSE, 2'($urandom_range(0, 3)), 8'd0));
      end
      1: begin
        closing_error = "close bracket of another kind";
        k = 2'($urandom_range(0, 3));
        send_beat(token_of(CLS_OPEN, k, 8'd0));
        send_beat(token_of(CLS_CLOSE, 2'(k ^ $urandom_range(1, 3)), 8'd0));
      end
      2: begin
        closing_error = "misaligned unindent";
        lo = $urandom_range(2, 100);
        hi = lo + $urandom_range(2, 100);
        send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'(lo)));
        send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'(hi)));
        send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'($urandom_range(lo + 1, hi - 1))));
      end
      3: begin
        closing_error = "bracket overflow";
        for (int i = 0; i <= BDEPTH; i++)
          send_beat(token_of(CLS_OPEN, 2'($urandom_range(0, 3)), 8'd0));
      end
      default: begin
        closing_error = "indent overflow";
        climb_indents(IDEPTH - 1);
        send_beat(token_of(CLS_NEWLINE, BK_PAREN, 8'd255));
      end
    endcase
    // halted block swallows everything
    for (int i = 0; i < 3; i++)
      send_beat(token_of(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 8'($urandom)));
    send_beat(eoi_beat());
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
    end
  endfunction

  // output side: random stall, long hold on request, compare each beat
  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) input_stalls++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      seen_res = '{kind: out_kind_o, code: out_token_code_o, err: error_code_o,
                   pos: out_position_o, last: last_o};
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, got kind %0d code %0h err %0d pos %0h",
                 $time, seen_res.kind, seen_res.code, seen_res.err, seen_res.pos);
      end else begin
        want_res = owed_results.pop_front();
        check_field("kind", 32'(want_res.kind), 32'(seen_res.kind));
        check_field("token code", 32'(want_res.code), 32'(seen_res.code));
        check_field("error code", 32'(want_res.err), 32'(seen_res.err));
        check_field("position", want_res.pos, seen_res.pos);
        check_field("last", 32'(want_res.last), 32'(seen_res.last));
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, %0d beats still owed", $time, owed_results.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    level_shadow[0] = 8'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 70;
    test_directed();
    test_deep_stacks();

    send_idle_pct = 70;
    recv_idle_pct = 9;
    test_random_stream(5);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(5);
    test_backpressure();
    test_halt_on_error();

    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d token beats in, %0d output beats checked, %0d stalled input cycles",
             beats_sent, results_seen, input_stalls);
    $display("deep stacks, dedent runs, end of input and halt after: %s", closing_error);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
